// File: rtl/cor_pkg.sv
// Shared types, codes and micro-op tables for the camera orbit rotator.
// No dependencies; imported by cor_ctrl, cor_dpath and camera_orbit_rotator.
package cor_pkg;

    localparam logic [2:0] DIR_LEFT  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;

    localparam logic [2:0] REG_COS = 3'd0;
    localparam logic [2:0] REG_SIN = 3'd4;

    localparam int CROSS_LEN = 9;
    localparam int SQ_LEN    = 4;
    localparam int ROT_LEN   = 27;

    typedef enum logic [1:0] {K_NOP, K_MUL, K_SQ, K_ST} t_kind;

    typedef enum logic [4:0] {
        O_A0, O_A1, O_A2, O_P0, O_P1, O_P2, O_L0, O_L1, O_L2,
        O_U0, O_U1, O_U2, O_N0, O_N1, O_N2, O_CR0, O_CR1, O_CR2,
        O_DOT, O_T, O_S, O_C, O_OMC
    } t_opnd;

    typedef enum logic [3:0] {
        D_CR0, D_CR1, D_CR2, D_DOT, D_T, D_P0, D_P1, D_P2, D_N0, D_N1, D_N2
    } t_dst;

    typedef struct packed {
        t_kind kind;
        logic  clr;
        logic  sub;
        t_opnd sel_a;
        t_opnd sel_b;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        t_uop       uop;
        logic       start;
        logic       neg_s;
        logic       axis_ax;
        logic       tgt_up;
        logic       sqrt_go;
        logic       div_go;
        logic [1:0] div_idx;
        logic       ax_load;
        logic       out_load;
        logic       degen;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic len_zero;
    } t_stat;

    function automatic t_uop mk(input t_kind k, input logic c, input logic s,
                                input t_opnd a, input t_opnd b, input t_dst d);
        t_uop u;
        u.kind  = k;
        u.clr   = c;
        u.sub   = s;
        u.sel_a = a;
        u.sel_b = b;
        u.dst   = d;
        return u;
    endfunction

    localparam t_uop NOP_UOP = '{kind: K_NOP, clr: 1'b0, sub: 1'b0,
                                 sel_a: O_A0, sel_b: O_A0, dst: D_T};

    // r = a x b, three rows per component: first product, minus second, store
    function automatic t_uop cross_row(input logic [4:0] idx,
                                       input t_opnd a0, input t_opnd a1, input t_opnd a2,
                                       input t_opnd b0, input t_opnd b1, input t_opnd b2,
                                       input t_dst d0, input t_dst d1, input t_dst d2);
        t_uop u;
        u = NOP_UOP;
        unique case (idx)
            5'd0:    u = mk(K_MUL, 1'b1, 1'b0, a1, b2, d0);
            5'd1:    u = mk(K_MUL, 1'b0, 1'b1, a2, b1, d0);
            5'd2:    u = mk(K_ST,  1'b0, 1'b0, a0, a0, d0);
            5'd3:    u = mk(K_MUL, 1'b1, 1'b0, a2, b0, d1);
            5'd4:    u = mk(K_MUL, 1'b0, 1'b1, a0, b2, d1);
            5'd5:    u = mk(K_ST,  1'b0, 1'b0, a0, a0, d1);
            5'd6:    u = mk(K_MUL, 1'b1, 1'b0, a0, b1, d2);
            5'd7:    u = mk(K_MUL, 1'b0, 1'b1, a1, b0, d2);
            5'd8:    u = mk(K_ST,  1'b0, 1'b0, a0, a0, d2);
            default: u = NOP_UOP;
        endcase
        return u;
    endfunction

    // Rodrigues step on target P about axis A:
    // P' = c*P + s*(A x P) + (1-c)*(A.P)*A
    function automatic t_uop rot_uop(input logic [4:0] idx);
        t_uop u;
        u = NOP_UOP;
        if (idx < 5'(CROSS_LEN)) begin
            u = cross_row(idx, O_A0, O_A1, O_A2, O_P0, O_P1, O_P2, D_CR0, D_CR1, D_CR2);
        end else begin
            unique case (idx)
                5'd9:    u = mk(K_MUL, 1'b1, 1'b0, O_A0, O_P0, D_DOT);
                5'd10:   u = mk(K_MUL, 1'b0, 1'b0, O_A1, O_P1, D_DOT);
                5'd11:   u = mk(K_MUL, 1'b0, 1'b0, O_A2, O_P2, D_DOT);
                5'd12:   u = mk(K_ST,  1'b0, 1'b0, O_A0, O_A0, D_DOT);
                5'd13:   u = mk(K_MUL, 1'b1, 1'b0, O_OMC, O_DOT, D_T);
                5'd14:   u = mk(K_ST,  1'b0, 1'b0, O_A0, O_A0, D_T);
                5'd15:   u = mk(K_MUL, 1'b1, 1'b0, O_S, O_CR0, D_P0);
                5'd16:   u = mk(K_MUL, 1'b0, 1'b0, O_T, O_A0, D_P0);
                5'd17:   u = mk(K_MUL, 1'b0, 1'b0, O_C, O_P0, D_P0);
                5'd18:   u = mk(K_ST,  1'b0, 1'b0, O_A0, O_A0, D_P0);
                5'd19:   u = mk(K_MUL, 1'b1, 1'b0, O_S, O_CR1, D_P1);
                5'd20:   u = mk(K_MUL, 1'b0, 1'b0, O_T, O_A1, D_P1);
                5'd21:   u = mk(K_MUL, 1'b0, 1'b0, O_C, O_P1, D_P1);
                5'd22:   u = mk(K_ST,  1'b0, 1'b0, O_A0, O_A0, D_P1);
                5'd23:   u = mk(K_MUL, 1'b1, 1'b0, O_S, O_CR2, D_P2);
                5'd24:   u = mk(K_MUL, 1'b0, 1'b0, O_T, O_A2, D_P2);
                5'd25:   u = mk(K_MUL, 1'b0, 1'b0, O_C, O_P2, D_P2);
                5'd26:   u = mk(K_ST,  1'b0, 1'b0, O_A0, O_A0, D_P2);
                default: u = NOP_UOP;
            endcase
        end
        return u;
    endfunction

endpackage

// File: rtl/cor_sqrt.sv
// Bit-serial floor integer square root, two radicand bits per cycle.
// Standalone; used by cor_dpath for the axis length.
module cor_sqrt #(
    parameter int W = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [2*W-1:0] i_rad,
    output logic           o_done,
    output logic [W-1:0]   o_root
);
    localparam int CW = $clog2(W + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_rad;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [W+1:0]   w_remsh;
    logic [W+1:0]   w_trial;

    assign w_remsh = {r_rem[W-1:0], r_rad[2*W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (w_remsh >= w_trial) begin
                r_rem  <= w_remsh - w_trial;
                r_root <= {r_root[W-2:0], 1'b1};
            end else begin
                r_rem  <= w_remsh;
                r_root <= {r_root[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// File: rtl/cor_div.sv
// Restoring divider: round(mag * 2^FRAC_BITS / len), one quotient bit a cycle.
// Standalone; used by cor_dpath to normalize the axis. Requires mag <= len.
module cor_div #(
    parameter int FRAC_BITS = 16,
    localparam int W = FRAC_BITS + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [W-1:0]       i_mag,
    input  logic [W-1:0]       i_len,
    output logic               o_done,
    output logic [FRAC_BITS:0] o_quo
);
    localparam int NW = W + FRAC_BITS;
    localparam int QB = FRAC_BITS + 1;
    localparam int CW = $clog2(QB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_len;
    logic [QB-1:0] r_low;
    logic [QB-1:0] r_q;
    logic [NW-1:0] w_num;
    logic [W:0]    w_rsh;

    // quotient stays below 2^QB, so the top bits already sit below len
    assign w_num = {i_mag, {FRAC_BITS{1'b0}}} + NW'(i_len >> 1);
    assign w_rsh = {r_rem, r_low[QB-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= {1'b0, w_num[NW-1:QB]};
            r_low <= w_num[QB-1:0];
            r_len <= i_len;
            r_q   <= '0;
        end else if (r_busy) begin
            r_low <= r_low << 1;
            if (w_rsh >= {1'b0, r_len}) begin
                r_rem <= W'(w_rsh - {1'b0, r_len});
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh[W-1:0];
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// File: rtl/cor_dpath.sv
// Datapath: vector state, shared multiply-accumulate, square root and divider.
// Depends on cor_pkg, cor_sqrt and cor_div; driven by cor_ctrl commands.
module cor_dpath import cor_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int W = FRAC_BITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic signed [W-1:0] i_cos,
    input  logic signed [W-1:0] i_sin,
    output t_stat               o_stat,
    output logic signed [W-1:0] o_eye [3],
    output logic signed [W-1:0] o_up [3],
    output logic                o_degen
);
    localparam int PW = 2 * (W + 1);
    localparam int AW = W + 4;
    localparam int SW = 2 * W;
    localparam logic signed [AW-1:0] SMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [PW-1:0]        HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [W+1:0]  ONE  = (W+2)'(1) << FRAC_BITS;

    logic signed [W-1:0] r_eye [3];
    logic signed [W-1:0] r_up [3];
    logic signed [W-1:0] r_ax [3];
    logic signed [W-1:0] r_n [3];
    logic signed [W-1:0] r_cr [3];
    logic signed [W-1:0] r_dot, r_t, r_c, r_omc;
    logic signed [W:0]   r_s;
    logic signed [PW-1:0] r_p;
    logic                r_pv_mul, r_pv_sq, r_pclr, r_psub;
    logic signed [AW-1:0] r_acc;
    logic [SW-1:0]       r_sumsq;

    logic signed [W:0]    w_a, w_b;
    logic signed [PW-1:0] w_prod;
    logic [PW-1:0]        w_mag, w_rnd;
    logic signed [AW-1:0] w_rnd_a, w_term, w_acc_n;
    logic signed [W-1:0]  w_sat;
    logic signed [W+1:0]  w_omc_full;
    logic signed [W:0]    w_sin_x;
    logic [W-1:0]         w_root;
    logic [W-1:0]         w_nmag;
    logic                 w_sqrt_done, w_div_done;
    logic [FRAC_BITS:0]   w_quo;
    logic signed [W-1:0]  w_qs;

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] v);
        if (v > SMAX) return SMAX[W-1:0];
        if (v < SMIN) return SMIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic signed [W:0] pick(input t_opnd sel, input logic ax_on,
                                               input logic tgt_up);
        logic signed [W:0] v;
        v = '0;
        unique case (sel)
            O_A0:    v = ax_on ? ext(r_ax[0]) : ext(r_up[0]);
            O_A1:    v = ax_on ? ext(r_ax[1]) : ext(r_up[1]);
            O_A2:    v = ax_on ? ext(r_ax[2]) : ext(r_up[2]);
            O_P0:    v = tgt_up ? ext(r_up[0]) : ext(r_eye[0]);
            O_P1:    v = tgt_up ? ext(r_up[1]) : ext(r_eye[1]);
            O_P2:    v = tgt_up ? ext(r_up[2]) : ext(r_eye[2]);
            O_L0:    v = -ext(r_eye[0]);
            O_L1:    v = -ext(r_eye[1]);
            O_L2:    v = -ext(r_eye[2]);
            O_U0:    v = ext(r_up[0]);
            O_U1:    v = ext(r_up[1]);
            O_U2:    v = ext(r_up[2]);
            O_N0:    v = ext(r_n[0]);
            O_N1:    v = ext(r_n[1]);
            O_N2:    v = ext(r_n[2]);
            O_CR0:   v = ext(r_cr[0]);
            O_CR1:   v = ext(r_cr[1]);
            O_CR2:   v = ext(r_cr[2]);
            O_DOT:   v = ext(r_dot);
            O_T:     v = ext(r_t);
            O_S:     v = r_s;
            O_C:     v = ext(r_c);
            O_OMC:   v = ext(r_omc);
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_a = pick(i_cmd.uop.sel_a, i_cmd.axis_ax, i_cmd.tgt_up);
        w_b = pick(i_cmd.uop.sel_b, i_cmd.axis_ax, i_cmd.tgt_up);
    end

    assign w_prod = w_a * w_b;

    // round half away from zero on the magnitude, then restore the sign, flipped for a subtract
    assign w_mag   = r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
    assign w_rnd   = (w_mag + HALF) >> FRAC_BITS;
    assign w_rnd_a = AW'(w_rnd);
    assign w_term  = (r_p[PW-1] ^ r_psub) ? -w_rnd_a : w_rnd_a;
    assign w_acc_n = r_pv_mul ? ((r_pclr ? '0 : r_acc) + w_term) : r_acc;
    assign w_sat   = sat_w(w_acc_n);

    assign w_omc_full = ONE - {{2{i_cos[W-1]}}, i_cos};
    assign w_sin_x    = ext(i_sin);

    assign w_nmag = r_n[i_cmd.div_idx][W-1] ? W'(-r_n[i_cmd.div_idx])
                                            : W'(r_n[i_cmd.div_idx]);
    assign w_qs   = r_n[i_cmd.div_idx][W-1] ? -W'({1'b0, w_quo}) : W'({1'b0, w_quo});

    cor_sqrt #(.W(W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_rad   (r_sumsq),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    cor_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_mag   (w_nmag),
        .i_len   (w_root),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.len_zero  = (w_root == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv_mul <= 1'b0;
            r_pv_sq  <= 1'b0;
            r_eye[0] <= '0;
            r_eye[1] <= '0;
            r_eye[2] <= ONE[W-1:0];
            r_up[0]  <= '0;
            r_up[1]  <= ONE[W-1:0];
            r_up[2]  <= '0;
        end else begin
            r_pv_mul <= (i_cmd.uop.kind == K_MUL);
            r_pv_sq  <= (i_cmd.uop.kind == K_SQ);
            if (i_cmd.uop.kind == K_ST) begin
                if (i_cmd.uop.dst == D_P0 && !i_cmd.tgt_up) r_eye[0] <= w_sat;
                if (i_cmd.uop.dst == D_P1 && !i_cmd.tgt_up) r_eye[1] <= w_sat;
                if (i_cmd.uop.dst == D_P2 && !i_cmd.tgt_up) r_eye[2] <= w_sat;
                if (i_cmd.uop.dst == D_P0 && i_cmd.tgt_up)  r_up[0]  <= w_sat;
                if (i_cmd.uop.dst == D_P1 && i_cmd.tgt_up)  r_up[1]  <= w_sat;
                if (i_cmd.uop.dst == D_P2 && i_cmd.tgt_up)  r_up[2]  <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= w_prod;
        r_pclr <= i_cmd.uop.clr;
        r_psub <= i_cmd.uop.sub;
        r_acc  <= w_acc_n;
        if (r_pv_sq) begin
            r_sumsq <= (r_pclr ? '0 : r_sumsq) + r_p[SW-1:0];
        end
        if (i_cmd.start) begin
            r_c    <= i_cos;
            r_s    <= i_cmd.neg_s ? -w_sin_x : w_sin_x;
            r_omc  <= sat_w(AW'(w_omc_full));
        end
        if (i_cmd.uop.kind == K_ST) begin
            unique case (i_cmd.uop.dst)
                D_CR0:   r_cr[0] <= w_sat;
                D_CR1:   r_cr[1] <= w_sat;
                D_CR2:   r_cr[2] <= w_sat;
                D_DOT:   r_dot   <= w_sat;
                D_T:     r_t     <= w_sat;
                D_N0:    r_n[0]  <= w_sat;
                D_N1:    r_n[1]  <= w_sat;
                D_N2:    r_n[2]  <= w_sat;
                D_P0, D_P1, D_P2: ;
                default: ;
            endcase
        end
        if (i_cmd.ax_load) begin
            r_ax[i_cmd.div_idx] <= w_qs;
        end
        if (i_cmd.out_load) begin
            o_eye   <= r_eye;
            o_up    <= r_up;
            o_degen <= i_cmd.degen;
        end
    end
endmodule

// File: rtl/cor_ctrl.sv
// Sequencer: walks the micro-op tables and steps the sqrt/divide units.
// Depends on cor_pkg; drives cor_dpath through t_cmd, reads t_stat.
module cor_ctrl import cor_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_direction,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_CROSS, S_SQ, S_SQRT, S_DIV, S_ROT, S_DONE
    } t_state;

    t_state     r_state;
    logic [4:0] r_pc;
    logic [1:0] r_idx;
    logic       r_axis_ax;
    logic       r_tgt_up;
    logic       r_degen;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_lr, w_ud;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_lr = (i_direction == DIR_LEFT) || (i_direction == DIR_RIGHT);
    assign w_ud = (i_direction == DIR_UP) || (i_direction == DIR_DOWN);

    always_comb begin
        o_cmd         = '0;
        o_cmd.uop     = NOP_UOP;
        o_cmd.axis_ax = r_axis_ax;
        o_cmd.tgt_up  = r_tgt_up;
        o_cmd.degen   = r_degen;
        o_cmd.div_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.start = w_accept;
                o_cmd.neg_s = (i_direction == DIR_RIGHT) || (i_direction == DIR_DOWN);
            end
            S_CROSS: begin
                o_cmd.uop = cross_row(r_pc, O_L0, O_L1, O_L2, O_U0, O_U1, O_U2,
                                      D_N0, D_N1, D_N2);
            end
            S_SQ: begin
                unique case (r_pc)
                    5'd0:    o_cmd.uop = mk(K_SQ, 1'b1, 1'b0, O_N0, O_N0, D_T);
                    5'd1:    o_cmd.uop = mk(K_SQ, 1'b0, 1'b0, O_N1, O_N1, D_T);
                    5'd2:    o_cmd.uop = mk(K_SQ, 1'b0, 1'b0, O_N2, O_N2, D_T);
                    default: o_cmd.uop = NOP_UOP;
                endcase
            end
            S_SQRT: o_cmd.sqrt_go = (r_pc == '0);
            S_DIV: begin
                o_cmd.div_go  = (r_pc == '0);
                o_cmd.ax_load = (r_pc != '0) && i_stat.div_done;
            end
            S_ROT:  o_cmd.uop = rot_uop(r_pc);
            S_DONE: o_cmd.out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_idx       <= '0;
            r_axis_ax   <= 1'b0;
            r_tgt_up    <= 1'b0;
            r_degen     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_degen   <= 1'b0;
                        r_pc      <= '0;
                        r_axis_ax <= 1'b0;
                        r_tgt_up  <= 1'b0;
                        priority if (w_lr) r_state <= S_ROT;
                        else if (w_ud)     r_state <= S_CROSS;
                        else               r_state <= S_DONE;
                    end
                end
                S_CROSS: begin
                    if (r_pc == 5'(CROSS_LEN - 1)) begin
                        r_pc    <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_SQ: begin
                    if (r_pc == 5'(SQ_LEN - 1)) begin
                        r_pc    <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_pc == '0) begin
                        r_pc <= 5'd1;
                    end else if (i_stat.sqrt_done) begin
                        r_pc <= '0;
                        if (i_stat.len_zero) begin
                            r_degen <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_pc == '0) begin
                        r_pc <= 5'd1;
                    end else if (i_stat.div_done) begin
                        r_pc <= '0;
                        if (r_idx == 2'd2) begin
                            r_axis_ax <= 1'b1;
                            r_tgt_up  <= 1'b0;
                            r_state   <= S_ROT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_ROT: begin
                    if (r_pc == 5'(ROT_LEN - 1)) begin
                        r_pc <= '0;
                        if (r_axis_ax && !r_tgt_up) begin
                            r_tgt_up <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_DONE: begin
                    if (o_cmd.out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/camera_orbit_rotator.sv
// Camera orbit rotator: Rodrigues rotation of eye/up vectors, Q2.FRAC_BITS.
// One shared multiplier, serial sqrt and divider. One word in flight: next word accepted
// the cycle after the result loads, held off while a finished result waits on a stalled output.
// Reset (sync, active low): eye (0,0,1), up (0,1,0), cos/sin to the pi/8 step.
// Depends on cor_pkg, cor_ctrl, cor_dpath.
module camera_orbit_rotator import cor_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int W = FRAC_BITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_direction,
    // result word
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [W-1:0] o_eye_x,
    output logic signed [W-1:0] o_eye_y,
    output logic signed [W-1:0] o_eye_z,
    output logic signed [W-1:0] o_up_x,
    output logic signed [W-1:0] o_up_y,
    output logic signed [W-1:0] o_up_z,
    output logic                o_degenerate_axis,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    // reset values scaled from the Q2.16 step of pi/8
    localparam logic [63:0] COS_RST = (64'd60547 << FRAC_BITS) >> 16;
    localparam logic [63:0] SIN_RST = (64'd25080 << FRAC_BITS) >> 16;

    logic signed [W-1:0] r_step_cosine;
    logic signed [W-1:0] r_step_sine;
    logic                w_wr;
    t_cmd                w_cmd;
    t_stat               w_stat;
    logic signed [W-1:0] w_eye [3];
    logic signed [W-1:0] w_up [3];

    // APB: no wait states, writes land on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(r_step_sine) : 32'(r_step_cosine);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cosine <= COS_RST[W-1:0];
            r_step_sine   <= SIN_RST[W-1:0];
        end else if (w_wr) begin
            unique case ({paddr[2], 2'b00})
                REG_COS: r_step_cosine <= pwdata[W-1:0];
                REG_SIN: r_step_sine   <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    // controller: sequences cross product, length, normalize and rotations
    cor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_direction (i_direction),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: vector state, MAC, sqrt, divider and output register
    cor_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cos   (r_step_cosine),
        .i_sin   (r_step_sine),
        .o_stat  (w_stat),
        .o_eye   (w_eye),
        .o_up    (w_up),
        .o_degen (o_degenerate_axis)
    );

    assign o_eye_x = w_eye[0];
    assign o_eye_y = w_eye[1];
    assign o_eye_z = w_eye[2];
    assign o_up_x  = w_up[0];
    assign o_up_y  = w_up[1];
    assign o_up_z  = w_up[2];

    // an accepted word always starts work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block idle right after accepting a word");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded while result still stalled");

    // sqrt and divider never finish together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.sqrt_done && w_stat.div_done))
        else $error("sqrt and divide completed in the same cycle");
endmodule
